### hdl/ctrf_pkg.sv
package ctrf_pkg;

    // Default fragment capacity of one set
    localparam int MAX_FRAGMENTS_DEF = 64;

    // Most loci reported for one set
    localparam int OUT_LIMIT = 62;

    // Threshold register
    localparam int          MIN_COV_W     = 7;
    localparam logic [6:0]  MIN_COV_RESET = 7'd3;

    // Field widths
    localparam int POS_W   = 32;
    localparam int CHROM_W = 10;
    localparam int CELL_W  = 20;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_STEP,
        ST_OUT_RD,
        ST_OUT_SHOW
    } ctrf_state_t;

endpackage

### hdl/ctrf_ram.sv
module ctrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/coverage_threshold_run_finder.sv
// Fragments load at one per cycle into the fragment store (MAX_FRAGMENTS deep).
// On the last fragment the sweep runs: for K distinct event positions over N stored
// fragments it makes K+1 passes, each a scan of the store followed by the step state,
// then shows each locus from the run store through a read state and a show state.
// No fragment is taken during the sweep or while loci are shown.
// rst_n (asynchronous, active low) clears the sequencer, counters and threshold to 3.
module coverage_threshold_run_finder
    import ctrf_pkg::*;
#(
    parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Threshold write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,      // min_coverage
    // Fragment input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // frag_start, frag_end, chrom_id, cell_id, zero pad
    input  logic        s_axis_tlast,  // last_fragment
    // Locus output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // locus_chrom, locus_cell, locus_first, locus_final, pad
    output logic        m_axis_tuser,  // overflowed
    output logic        m_axis_tlast   // last_locus
);

    localparam int AW = $clog2(MAX_FRAGMENTS);
    localparam int CW = $clog2(MAX_FRAGMENTS + 1);

    ctrf_state_t state_reg, state_next;

    logic [MIN_COV_W-1:0] min_cov_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic                 drop_reg, drop_next;
    logic [CHROM_W-1:0]   chrom_reg, chrom_next;
    logic [CELL_W-1:0]    cell_reg, cell_next;

    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     min_pos_reg, min_pos_next;
    logic signed [CW:0]   delta_reg, delta_next;
    logic                 started_reg, started_next;
    logic [POS_W-1:0]     prev_reg, prev_next;
    logic [CW-1:0]        cov_reg, cov_next;
    logic                 in_run_reg, in_run_next;
    logic [POS_W-1:0]     run_begin_reg, run_begin_next;
    logic [CW-1:0]        run_cnt_reg, run_cnt_next;
    logic                 lost_reg, lost_next;
    logic [CW-1:0]        out_idx_reg, out_idx_next;

    logic [POS_W-1:0]     in_start, in_end;
    logic                 in_accept, frag_nonempty;
    logic                 frag_wr_en;
    logic [2*POS_W-1:0]   frag_rd_data;
    logic [POS_W-1:0]     st_pos, en_pos;
    logic                 st_gt, en_gt, cand_ok;
    logic [POS_W-1:0]     cand_pos;
    logic signed [CW:0]   cand_delta;
    logic                 run_wr_en;
    logic [2*POS_W-1:0]   run_wr_data, run_rd_data;
    logic                 record;
    logic                 scan_done;
    logic                 last_out;

    assign in_start      = s_axis_tdata[31:0];
    assign in_end        = s_axis_tdata[63:32];
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign frag_nonempty = in_end > in_start;
    assign frag_wr_en    = in_accept && frag_nonempty && (int'(count_reg) < MAX_FRAGMENTS);
    assign scan_done     = (rd_idx_reg == count_reg) && !pend_reg;
    assign last_out      = (out_idx_reg + CW'(1)) == run_cnt_reg;

    // Fragment store: start in the low half, end in the high half
    ctrf_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (MAX_FRAGMENTS)
    ) u_frag_ram (
        .clk     (clk),
        .wr_en   (frag_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({in_end, in_start}),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (frag_rd_data)
    );

    // Run store: first in the low half, final in the high half
    ctrf_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (MAX_FRAGMENTS)
    ) u_run_ram (
        .clk     (clk),
        .wr_en   (run_wr_en),
        .wr_addr (run_cnt_reg[AW-1:0]),
        .wr_data (run_wr_data),
        .rd_addr (out_idx_reg[AW-1:0]),
        .rd_data (run_rd_data)
    );

    // Smallest event of one fragment above the current position
    always_comb
    begin
        st_pos     = frag_rd_data[POS_W-1:0];
        en_pos     = frag_rd_data[2*POS_W-1:POS_W];
        st_gt      = !started_reg || (st_pos > prev_reg);
        en_gt      = !started_reg || (en_pos > prev_reg);
        cand_ok    = st_gt || en_gt;
        cand_pos   = st_gt ? st_pos : en_pos;
        cand_delta = st_gt ? (CW+1)'(1) : -(CW+1)'(1);
    end

    // Datapath next values
    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        chrom_next     = chrom_reg;
        cell_next      = cell_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        min_pos_next   = min_pos_reg;
        delta_next     = delta_reg;
        started_next   = started_reg;
        prev_next      = prev_reg;
        cov_next       = cov_reg;
        in_run_next    = in_run_reg;
        run_begin_next = run_begin_reg;
        run_cnt_next   = run_cnt_reg;
        lost_next      = lost_reg;
        out_idx_next   = out_idx_reg;
        record         = 1'b0;
        run_wr_en      = 1'b0;
        run_wr_data    = {prev_reg, run_begin_reg + POS_W'(1)};

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    chrom_next = s_axis_tdata[73:64];
                    cell_next  = s_axis_tdata[93:74];
                    if (frag_nonempty)
                    begin
                        if (int'(count_reg) < MAX_FRAGMENTS)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        rd_idx_next  = '0;
                        pend_next    = 1'b0;
                        found_next   = 1'b0;
                        started_next = 1'b0;
                        cov_next     = '0;
                        in_run_next  = 1'b0;
                        run_cnt_next = '0;
                        lost_next    = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue reads and fold returned entries into the minimum
                pend_next = rd_idx_reg < count_reg;
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (pend_reg && cand_ok)
                begin
                    if (!found_reg || (cand_pos < min_pos_reg))
                    begin
                        found_next   = 1'b1;
                        min_pos_next = cand_pos;
                        delta_next   = cand_delta;
                    end
                    else if (cand_pos == min_pos_reg)
                    begin
                        delta_next = delta_reg + cand_delta;
                    end
                end
            end
            ST_STEP:
            begin
                rd_idx_next  = '0;
                pend_next    = 1'b0;
                found_next   = 1'b0;
                out_idx_next = '0;
                if (found_reg)
                begin
                    if (started_reg)
                    begin
                        if (int'(cov_reg) >= int'(min_cov_reg))
                        begin
                            if (!in_run_reg)
                            begin
                                run_begin_next = prev_reg;
                                in_run_next    = 1'b1;
                            end
                        end
                        else if (in_run_reg)
                        begin
                            record      = 1'b1;
                            in_run_next = 1'b0;
                        end
                    end
                    cov_next     = CW'($signed({1'b0, cov_reg}) + delta_reg);
                    prev_next    = min_pos_reg;
                    started_next = 1'b1;
                end
                else
                begin
                    if (in_run_reg)
                    begin
                        record      = 1'b1;
                        in_run_next = 1'b0;
                    end
                end
                // Store a finished run, or mark it lost
                if (record)
                begin
                    if (int'(run_cnt_reg) < OUT_LIMIT)
                    begin
                        run_wr_en    = 1'b1;
                        run_cnt_next = run_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
                if (!found_reg && (run_cnt_next == '0))
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                end
            end
            ST_OUT_RD:
            begin
            end
            ST_OUT_SHOW:
            begin
                if (m_axis_tready)
                begin
                    out_idx_next = out_idx_reg + CW'(1);
                    if (last_out)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && s_axis_tlast)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (found_reg)
                begin
                    state_next = ST_SCAN;
                end
                else if (run_cnt_next != '0)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_SHOW;
            end
            ST_OUT_SHOW:
            begin
                if (m_axis_tready)
                begin
                    state_next = last_out ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_LOAD:     s_axis_tready = 1'b1;
            ST_OUT_SHOW: m_axis_tvalid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b00, run_rd_data, cell_reg, chrom_reg};
    assign m_axis_tuser = drop_reg || lost_reg;
    assign m_axis_tlast = last_out;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            min_cov_reg <= MIN_COV_RESET;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            chrom_reg   <= '0;
            cell_reg    <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            started_reg <= 1'b0;
            in_run_reg  <= 1'b0;
            run_cnt_reg <= '0;
            lost_reg    <= 1'b0;
            out_idx_reg <= '0;
            cov_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                min_cov_reg <= cfg_data;
            end
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            chrom_reg   <= chrom_next;
            cell_reg    <= cell_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            started_reg <= started_next;
            in_run_reg  <= in_run_next;
            run_cnt_reg <= run_cnt_next;
            lost_reg    <= lost_next;
            out_idx_reg <= out_idx_next;
            cov_reg     <= cov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        min_pos_reg   <= min_pos_next;
        delta_reg     <= delta_next;
        prev_reg      <= prev_next;
        run_begin_reg <= run_begin_next;
    end

endmodule
